>>> rtl/core/fsat_pkg.sv
// Shared types and codes for the frame sequence acknowledge tracker.
// Used by fsat_step and frame_sequence_ack_tracker; depends on nothing else.
package fsat_pkg;

    // Result status codes.
    localparam logic [3:0] ST_CONTINUE      = 4'd0;
    localparam logic [3:0] ST_DONE          = 4'd1;
    localparam logic [3:0] ST_DUPLICATE     = 4'd2;
    localparam logic [3:0] ST_LOST_NAK      = 4'd3;
    localparam logic [3:0] ST_LOST_QUIET    = 4'd4;
    localparam logic [3:0] ST_TIMEOUT_RETRY = 4'd5;
    localparam logic [3:0] ST_TIMEOUT_ABORT = 4'd6;
    localparam logic [3:0] ST_LOSS_ABORT    = 4'd7;
    localparam logic [3:0] ST_BAD_FRAME     = 4'd8;
    localparam logic [3:0] ST_ZERO_FRAME    = 4'd9;

    // Kinds of command sent back to the transmitter.
    localparam logic [1:0] TX_NONE    = 2'd0;
    localparam logic [1:0] TX_SUCCESS = 2'd1;
    localparam logic [1:0] TX_FAILURE = 2'd2;
    localparam logic [1:0] TX_TIMEOUT = 2'd3;

    // Input command codes.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_FRAMES_PER_PACKAGE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT      = 2'd1;
    localparam logic [1:0] REG_LOSS_LIMIT         = 2'd2;

    // Register reset values.
    localparam logic [7:0] FRAMES_PER_PACKAGE_RST = 8'd255;
    localparam logic [1:0] TIMEOUT_LIMIT_RST      = 2'd2;
    localparam logic [1:0] LOSS_LIMIT_RST         = 2'd2;

    typedef struct packed {
        logic [7:0] frames_per_package;
        logic [1:0] timeout_limit;
        logic [1:0] loss_limit;
    } t_config;

    typedef struct packed {
        logic [7:0]  in_order_count;
        logic [7:0]  previous_frame;
        logic [7:0]  current_package;
        logic [7:0]  timed_out_package;
        logic [1:0]  timeout_count;
        logic [1:0]  loss_count;
        logic [7:0]  last_stored_package;
        logic [31:0] accepted_packages;
    } t_state;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  tx_kind;
        logic [7:0]  tx_package;
        logic [7:0]  lost_frames;
        logic        session_end;
        logic [31:0] packages_received;
    } t_result;

endpackage

>>> rtl/core/fsat_step.sv
// Per-transaction decision logic: next tracker state and result from one header or timeout.
// Depends on fsat_pkg for the state, configuration and result types and codes.
module fsat_step (
    input  logic               i_cmd,
    input  logic [7:0]         i_package_index,
    input  logic [7:0]         i_frame_index,
    input  fsat_pkg::t_config  i_cfg,
    input  fsat_pkg::t_state   i_state,
    output fsat_pkg::t_state   o_state,
    output fsat_pkg::t_result  o_result
);

    always_comb begin
        fsat_pkg::t_state  ns;
        fsat_pkg::t_result res;
        logic [7:0] prev_eff;
        logic [7:0] ioc_eff;
        logic [7:0] ioc_new;

        ns       = i_state;
        res      = '0;
        prev_eff = (i_frame_index == 8'd1) ? 8'd0 : i_state.previous_frame;
        ioc_eff  = (i_frame_index == 8'd1) ? 8'd0 : i_state.in_order_count;
        ioc_new  = ({1'b0, i_frame_index} == ({1'b0, prev_eff} + 9'd1)) ?
                   (ioc_eff + 8'd1) : 8'd0;
        res.status  = fsat_pkg::ST_CONTINUE;
        res.tx_kind = fsat_pkg::TX_NONE;

        if (i_cmd == fsat_pkg::CMD_TICK) begin
            if (i_state.in_order_count != 8'd0) begin
                ns.timed_out_package = i_state.current_package;
            end
            ns.in_order_count = 8'd0;
            ns.previous_frame = 8'd0;
            if (({1'b0, i_state.timeout_count} + 3'd1) >= {1'b0, i_cfg.timeout_limit}) begin
                res.status      = fsat_pkg::ST_TIMEOUT_ABORT;
                res.session_end = 1'b1;
            end else begin
                ns.timeout_count = i_state.timeout_count + 2'd1;
                res.status       = fsat_pkg::ST_TIMEOUT_RETRY;
                res.tx_kind      = fsat_pkg::TX_TIMEOUT;
                res.tx_package   = i_state.current_package;
            end
        end else begin
            ns.current_package = i_package_index;
            if (i_package_index == 8'd0 && i_frame_index == 8'd0) begin
                res.status = fsat_pkg::ST_ZERO_FRAME;
            end else if (i_frame_index == 8'd0 || i_frame_index > i_cfg.frames_per_package) begin
                res.status      = fsat_pkg::ST_BAD_FRAME;
                res.session_end = 1'b1;
            end else begin
                ns.in_order_count = ioc_new;
                ns.previous_frame = i_frame_index;
                if (ioc_new > i_cfg.frames_per_package) begin
                    res.status      = fsat_pkg::ST_BAD_FRAME;
                    res.session_end = 1'b1;
                end else if (i_frame_index == i_cfg.frames_per_package) begin
                    if (ioc_new == i_cfg.frames_per_package) begin
                        if (i_state.last_stored_package == i_package_index) begin
                            res.status = fsat_pkg::ST_DUPLICATE;
                        end else begin
                            ns.accepted_packages   = i_state.accepted_packages + 32'd1;
                            ns.last_stored_package = i_package_index;
                            res.status      = fsat_pkg::ST_DONE;
                            res.tx_kind     = fsat_pkg::TX_SUCCESS;
                            res.tx_package  = i_package_index;
                            res.session_end = 1'b1;
                        end
                    end else begin
                        res.lost_frames = i_cfg.frames_per_package - ioc_new;
                        if (i_state.timed_out_package == i_package_index) begin
                            res.status = fsat_pkg::ST_LOST_QUIET;
                        end else if (({1'b0, i_state.loss_count} + 3'd1) >=
                                     {1'b0, i_cfg.loss_limit}) begin
                            res.status      = fsat_pkg::ST_LOSS_ABORT;
                            res.session_end = 1'b1;
                        end else begin
                            ns.loss_count  = i_state.loss_count + 2'd1;
                            res.status     = fsat_pkg::ST_LOST_NAK;
                            res.tx_kind    = fsat_pkg::TX_FAILURE;
                            res.tx_package = i_package_index;
                        end
                    end
                    ns.in_order_count = 8'd0;
                    ns.previous_frame = 8'd0;
                end
            end
        end

        // A terminal outcome clears the session but keeps the persistent fields.
        if (res.session_end) begin
            ns.in_order_count    = 8'd0;
            ns.previous_frame    = 8'd0;
            ns.current_package   = 8'd0;
            ns.timed_out_package = 8'd0;
            ns.timeout_count     = 2'd0;
            ns.loss_count        = 2'd0;
        end

        res.packages_received = ns.accepted_packages;
        o_state  = ns;
        o_result = res;
    end

endmodule

>>> rtl/core/frame_sequence_ack_tracker.sv
// Top level of the frame sequence acknowledge tracker: handshakes, registers, APB port.
// Depends on fsat_pkg and instantiates fsat_step.

// The tracker takes one transaction per clock cycle when o_in_ready is high, either a
// frame header or a receive timeout tick, and returns exactly one result transaction
// for each. A transaction is captured in an input register, decided by a single short
// pass of compare logic in fsat_step, and the result lands in an output register that
// drives o_out_valid. The sustained rate is one transaction per cycle while i_out_ready
// stays high; that rate is set by the session state feedback from r_state through
// fsat_step and back. While a result waits on i_out_ready, the input register can still
// take one more transaction; once both registers are full, o_in_ready stays low until
// the waiting result is taken. The three configuration registers sit at byte addresses
// 0, 4 and 8 of the APB port and should only be written while no transaction is in
// flight.
module frame_sequence_ack_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_package_index,
    input  logic [7:0]  i_frame_index,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [1:0]  o_tx_kind,
    output logic [7:0]  o_tx_package,
    output logic [7:0]  o_lost_frames,
    output logic        o_session_end,
    output logic [31:0] o_packages_received,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    fsat_pkg::t_config r_cfg;
    logic              w_cfg_write;

    // Input register stage.
    logic       r_in_vld;
    logic       r_cmd;
    logic [7:0] r_package_index;
    logic [7:0] r_frame_index;

    // Tracker state and result register.
    fsat_pkg::t_state  r_state;
    fsat_pkg::t_state  n_state;
    fsat_pkg::t_result n_result;
    fsat_pkg::t_result r_result;
    logic              r_out_vld;

    logic w_in_accept;
    logic w_out_load;

    // The result register can take a new result when it is empty or being drained.
    assign w_out_load  = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_out_load;
    assign w_in_accept = i_in_valid && o_in_ready;

    // APB: zero wait states; a write lands on the access phase.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frames_per_package <= fsat_pkg::FRAMES_PER_PACKAGE_RST;
            r_cfg.timeout_limit      <= fsat_pkg::TIMEOUT_LIMIT_RST;
            r_cfg.loss_limit         <= fsat_pkg::LOSS_LIMIT_RST;
        end else if (w_cfg_write) begin
            case (paddr[3:2])
                fsat_pkg::REG_FRAMES_PER_PACKAGE: r_cfg.frames_per_package <= pwdata[7:0];
                fsat_pkg::REG_TIMEOUT_LIMIT:      r_cfg.timeout_limit      <= pwdata[1:0];
                fsat_pkg::REG_LOSS_LIMIT:         r_cfg.loss_limit         <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fsat_pkg::REG_FRAMES_PER_PACKAGE: prdata = {24'd0, r_cfg.frames_per_package};
            fsat_pkg::REG_TIMEOUT_LIMIT:      prdata = {30'd0, r_cfg.timeout_limit};
            fsat_pkg::REG_LOSS_LIMIT:         prdata = {30'd0, r_cfg.loss_limit};
            default:                          prdata = 32'd0;
        endcase
    end

    // Input register: the valid bit is control, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd           <= i_cmd;
            r_package_index <= i_package_index;
            r_frame_index   <= i_frame_index;
        end
    end

    fsat_step u_step (
        .i_cmd           (r_cmd),
        .i_package_index (r_package_index),
        .i_frame_index   (r_frame_index),
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // The tracker state advances exactly when a transaction moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_state <= n_state;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_status            = r_result.status;
    assign o_tx_kind           = r_result.tx_kind;
    assign o_tx_package        = r_result.tx_package;
    assign o_lost_frames       = r_result.lost_frames;
    assign o_session_end       = r_result.session_end;
    assign o_packages_received = r_result.packages_received;

    // A session end is reported only with a terminal status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_session_end) |->
            (o_status == fsat_pkg::ST_DONE || o_status == fsat_pkg::ST_TIMEOUT_ABORT ||
             o_status == fsat_pkg::ST_LOSS_ABORT || o_status == fsat_pkg::ST_BAD_FRAME))
        else $error("session end with a non-terminal status");

    // After a terminal outcome is loaded, the session state is clear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && n_result.session_end) |=>
            (r_state.in_order_count == 8'd0 && r_state.timeout_count == 2'd0 &&
             r_state.loss_count == 2'd0 && r_state.timed_out_package == 8'd0))
        else $error("session state not cleared after session end");

    // The package count only moves when a transaction is processed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_out_load)) |-> $stable(r_state.accepted_packages))
        else $error("package count changed without a transaction");

    // A result that sends nothing carries no package number.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_kind == fsat_pkg::TX_NONE) |-> (o_tx_package == 8'd0))
        else $error("package number present without a command");

endmodule
